FILE: rtl/lru_key_value_store_core_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value store assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_STORE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_STORE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value store package
// Sizes, opcodes, controller states and command types of the store.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lkv_state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
   } lkv_cmd_type;

endpackage

FILE: rtl/lkv_channels_if.sv
// ----------------------------------------------------------------------------
// LRU key-value store channels
// Request, response and capacity write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lkv_req_if;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [lkv_pkg::KEY_W-1:0] lookup_key;
   logic [lkv_pkg::VAL_W-1:0] store_value;

   modport source (output valid, output opcode, output lookup_key, output store_value,
                   input ready);
   modport sink   (input valid, input opcode, input lookup_key, input store_value,
                   output ready);
endinterface

interface lkv_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [lkv_pkg::VAL_W-1:0] read_value;
   logic                      evicted;
   logic [lkv_pkg::KEY_W-1:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

interface lkv_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lkv_pkg::CAP_W-1:0] capacity_in_use;

   modport source (output valid, output capacity_in_use, input ready);
   modport sink   (input valid, input capacity_in_use, output ready);
endinterface

FILE: rtl/lru_key_value_store_core.sv
// ----------------------------------------------------------------------------
// LRU key-value store core
// A fully associative store of 16 key-value entries with LRU replacement.
// A request carries an opcode (get or put), a key and a value; each request
// produces exactly one response with the hit flag, the read value (-1 on a
// miss and on every put) and, for a put that evicts, the evicted key.
// The csr channel sets the capacity in use; it is always ready and should be
// written only while no request is in flight.
// An accepted request passes through a lookup step, for the parallel key
// match and victim search, and an update step, for the value, rank and key
// update and the response register; the next request can be accepted there.
// The response sits in an output register; a stalled receiver holds the
// response and the core keeps it and stops taking requests after the next
// request has finished its lookup.
// Reset empties the store and sets the capacity in use to 16.
// ----------------------------------------------------------------------------
`include "lru_key_value_store_core_defines.svh"

module lru_key_value_store_core (
   input  logic      clock,
   input  logic      reset,
   lkv_req_if.sink   req,
   lkv_rsp_if.source rsp,
   lkv_csr_if.sink   csr
);

   lkv_pkg::lkv_cmd_type cmd;

   assign csr.ready = 1'b1;

   lkv_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd)
   );

   lkv_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_opcode          (req.opcode),
      .req_lookup_key      (req.lookup_key),
      .req_store_value     (req.store_value),
      .csr_write           (csr.valid),
      .csr_capacity_in_use (csr.capacity_in_use),
      .rsp_hit             (rsp.hit),
      .rsp_read_value      (rsp.read_value),
      .rsp_evicted         (rsp.evicted),
      .rsp_evicted_key     (rsp.evicted_key)
   );

   `LKV_ASSERT_NEXT(a_accept_then_lookup, req.valid && req.ready, cmd.lookup, "lookup did not follow accept")
   `LKV_ASSERT_SAME(a_no_accept_in_lookup, cmd.lookup, !req.ready, "request taken during lookup")
   `LKV_ASSERT_NEXT(a_commit_then_valid, cmd.commit, rsp.valid, "committed response not presented")
   `LKV_ASSERT_SAME(a_evict_only_on_miss, rsp.valid && rsp.evicted, !rsp.hit && rsp.read_value == lkv_pkg::MISS_VALUE, "eviction reported on a hit")

endmodule

FILE: rtl/lkv_controller.sv
// ----------------------------------------------------------------------------
// LRU key-value store controller
// Sequences each request through lookup and update and owns response valid.
// ----------------------------------------------------------------------------
module lkv_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lkv_pkg::lkv_cmd_type cmd
);

   lkv_pkg::lkv_state_type state_ff;
   lkv_pkg::lkv_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lkv_pkg::ST_LOOKUP;
            end
         end
         lkv_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = lkv_pkg::ST_UPDATE;
         end
         lkv_pkg::ST_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = lkv_pkg::ST_LOOKUP;
               end else begin
                  state_in = lkv_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

endmodule

FILE: rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// LRU key-value store datapath
// Entry storage, associative match, recency ranks and the response register.
// ----------------------------------------------------------------------------
module lkv_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lkv_pkg::lkv_cmd_type                cmd,
   input  logic                                req_opcode,
   input  logic [lkv_pkg::KEY_W-1:0]           req_lookup_key,
   input  logic [lkv_pkg::VAL_W-1:0]           req_store_value,
   input  logic                                csr_write,
   input  logic [lkv_pkg::CAP_W-1:0]           csr_capacity_in_use,
   output logic                                rsp_hit,
   output logic [lkv_pkg::VAL_W-1:0]           rsp_read_value,
   output logic                                rsp_evicted,
   output logic [lkv_pkg::KEY_W-1:0]           rsp_evicted_key
);

   // Captured request.
   logic                        op_ff;
   logic [lkv_pkg::KEY_W-1:0]   key_ff;
   logic [lkv_pkg::VAL_W-1:0]   val_ff;

   // Configuration and store state.
   logic [lkv_pkg::CAP_W-1:0]   cap_ff;
   logic [lkv_pkg::KEY_W-1:0]   keys_ff   [lkv_pkg::ENTRIES];
   logic [lkv_pkg::VAL_W-1:0]   values_ff [lkv_pkg::ENTRIES];
   logic [lkv_pkg::ENTRIES-1:0] valid_ff;
   logic [lkv_pkg::ENTRIES-1:0] valid_in;
   logic [lkv_pkg::RANK_W-1:0]  rank_ff   [lkv_pkg::ENTRIES];
   logic [lkv_pkg::RANK_W-1:0]  rank_in   [lkv_pkg::ENTRIES];
   logic [lkv_pkg::OCC_W-1:0]   occ_ff;
   logic [lkv_pkg::OCC_W-1:0]   occ_in;

   // Lookup stage results.
   logic                        hit_ff;
   logic                        hit_in;
   logic [lkv_pkg::IDX_W-1:0]   hit_idx_ff;
   logic [lkv_pkg::IDX_W-1:0]   hit_idx_in;
   logic [lkv_pkg::RANK_W-1:0]  hit_rank_ff;
   logic                        evict_ff;
   logic                        evict_in;
   logic [lkv_pkg::IDX_W-1:0]   victim_idx_ff;
   logic [lkv_pkg::IDX_W-1:0]   victim_idx_in;
   logic [lkv_pkg::IDX_W-1:0]   free_idx_ff;
   logic [lkv_pkg::IDX_W-1:0]   free_idx_in;
   logic [lkv_pkg::RANK_W-1:0]  victim_rank;
   logic [lkv_pkg::CMP_W-1:0]   eff_cap;

   // Update stage controls.
   logic                        is_put;
   logic                        insert;
   logic [lkv_pkg::IDX_W-1:0]   slot;

   // Response register.
   logic                        rsp_hit_ff;
   logic [lkv_pkg::VAL_W-1:0]   rsp_read_value_ff;
   logic                        rsp_evicted_ff;
   logic [lkv_pkg::KEY_W-1:0]   rsp_evicted_key_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_lookup_key;
         val_ff <= req_store_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else if (csr_write) begin
         cap_ff <= csr_capacity_in_use;
      end
   end

   // A capacity of zero acts as one, and values above the entry count saturate.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lkv_pkg::CMP_W'(1);
      end else if (lkv_pkg::CMP_W'(cap_ff) > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
         eff_cap = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
      end else begin
         eff_cap = lkv_pkg::CMP_W'(cap_ff);
      end
   end

   // The least recent valid entry always holds rank occupancy minus one.
   assign victim_rank = lkv_pkg::RANK_W'(occ_ff - lkv_pkg::OCC_W'(1));
   assign evict_in    = lkv_pkg::CMP_W'(occ_ff) >= eff_cap;

   always_comb begin
      hit_in        = 1'b0;
      hit_idx_in    = '0;
      victim_idx_in = '0;
      free_idx_in   = '0;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         if (valid_ff[i] && keys_ff[i] == key_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = hit_idx_in | lkv_pkg::IDX_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == victim_rank) begin
            victim_idx_in = victim_idx_in | lkv_pkg::IDX_W'(i);
         end
      end
      for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx_in = lkv_pkg::IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff        <= hit_in;
         hit_idx_ff    <= hit_idx_in;
         hit_rank_ff   <= rank_ff[hit_idx_in];
         evict_ff      <= evict_in;
         victim_idx_ff <= victim_idx_in;
         free_idx_ff   <= free_idx_in;
      end
   end

   assign is_put = op_ff == lkv_pkg::OP_PUT;
   assign insert = is_put && !hit_ff;
   assign slot   = evict_ff ? victim_idx_ff : free_idx_ff;

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit && hit_ff) begin
         for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (lkv_pkg::IDX_W'(i) == hit_idx_ff) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank_ff) begin
               rank_in[i] = rank_ff[i] + lkv_pkg::RANK_W'(1);
            end
         end
      end else if (cmd.commit && insert) begin
         for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (lkv_pkg::IDX_W'(i) == slot) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + lkv_pkg::RANK_W'(1);
            end
         end
         valid_in[slot] = 1'b1;
         if (!evict_ff) begin
            occ_in = occ_ff + lkv_pkg::OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_put) begin
         if (hit_ff) begin
            values_ff[hit_idx_ff] <= val_ff;
         end else begin
            values_ff[slot] <= val_ff;
            keys_ff[slot]   <= key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff         <= hit_ff;
         rsp_read_value_ff  <= (hit_ff && !is_put) ? values_ff[hit_idx_ff]
                                                    : lkv_pkg::MISS_VALUE;
         rsp_evicted_ff     <= insert && evict_ff;
         rsp_evicted_key_ff <= (insert && evict_ff) ? keys_ff[victim_idx_ff] : '0;
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule
